>>> hdl/igpc_pkg.sv
// ----------------------------------------------------------------------------
// igpc_pkg
// shared types and constants for the interlocked gate pulse controller
// ----------------------------------------------------------------------------
package igpc_pkg;

  localparam int CHANNELS = 3;
  localparam int GATE_W   = 3;
  localparam int MODE_W   = 6;

  localparam logic [2:0]  OC_MASK       = 3'((1 << CHANNELS) - 1);
  localparam logic [15:0] DUR_MIN       = 16'd1;
  localparam logic [15:0] DUR_MAX       = 16'd60000;
  localparam logic [13:0] CNT_MIN       = 14'd1;
  localparam logic [13:0] CNT_MAX       = 14'd10000;
  localparam logic [15:0] LEN_RESET     = 16'd100;
  localparam logic [15:0] WDOG_RESET    = 16'd1000;
  localparam logic        ILK_POL_RESET = 1'b1;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_CH_OFF    = 3'd1,
    ACT_CH_DC     = 3'd2,
    ACT_CH_PULSE  = 3'd3,
    ACT_STOP_ALL  = 3'd4,
    ACT_CLR_FAULT = 3'd5,
    ACT_KEEPALIVE = 3'd6,
    ACT_SPARE     = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    RC_OK            = 3'd0,
    RC_NOT_READY     = 3'd1,
    RC_BAD_CHAN      = 3'd2,
    RC_DUR_RANGE     = 3'd3,
    RC_CNT_RANGE     = 3'd4,
    RC_FAULT_ACTIVE  = 3'd5,
    RC_ILK_NOT_READY = 3'd6
  } rcode_t;

  typedef enum logic [1:0] {
    TOP_READY     = 2'd0,
    TOP_SAFE_ILK  = 2'd1,
    TOP_SAFE_WDOG = 2'd2,
    TOP_FAULT     = 2'd3
  } top_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_DC    = 2'd1,
    MODE_PULSE = 2'd2,
    MODE_TRAIN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CHCMD_NONE  = 2'd0,
    CHCMD_OFF   = 2'd1,
    CHCMD_DC    = 2'd2,
    CHCMD_PULSE = 2'd3
  } chcmd_t;

  typedef enum logic {
    CFG_WDOG_TIMEOUT = 1'b0,
    CFG_ILK_POL      = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] len;
    logic [13:0] left;
    logic [15:0] elapsed;
    logic        gap;
  } chan_t;

  typedef struct packed {
    logic        tick;
    logic        ready;
    chcmd_t      cmd;
    logic [15:0] dur;
    logic [13:0] cnt;
  } chctl_t;

  typedef struct packed {
    rcode_t              code;
    top_t                top;
    logic [GATE_W-1:0]   gates;
    logic [MODE_W-1:0]   modes;
    logic                fault;
  } result_t;

endpackage

>>> hdl/igpc_channel.sv
// ----------------------------------------------------------------------------
// igpc_channel
// next state and gate level of one gate channel for one transaction
// ----------------------------------------------------------------------------
module igpc_channel (
  input  igpc_pkg::chan_t  cur,
  input  igpc_pkg::chctl_t ctl,
  output igpc_pkg::chan_t  nxt,
  output logic             gate
);
  import igpc_pkg::*;

  chan_t s;

  always_comb begin
    s = cur;
    if (ctl.tick && (s.elapsed != 16'hFFFF)) begin
      s.elapsed = s.elapsed + 16'd1;
    end
    unique case (ctl.cmd)
      CHCMD_OFF: begin
        s.mode = MODE_OFF;
        s.left = '0;
        s.gap  = 1'b0;
      end
      CHCMD_DC: begin
        s.mode = MODE_DC;
        s.left = '0;
        s.gap  = 1'b0;
      end
      CHCMD_PULSE: begin
        s.mode    = (ctl.cnt == 14'd1) ? MODE_PULSE : MODE_TRAIN;
        s.len     = ctl.dur;
        s.left    = ctl.cnt;
        s.elapsed = '0;
        s.gap     = 1'b0;
      end
      default: ;
    endcase

    gate = 1'b0;
    if (ctl.ready) begin
      case (s.mode)
        MODE_DC: gate = 1'b1;
        MODE_PULSE: begin
          if (s.elapsed < s.len) begin
            gate = 1'b1;
          end else begin
            s.mode = MODE_OFF;
            s.left = '0;
          end
        end
        MODE_TRAIN: begin
          if (s.left == '0) begin
            s.mode = MODE_OFF;
            s.gap  = 1'b0;
          end else if (!s.gap) begin
            if (s.elapsed < s.len) begin
              gate = 1'b1;
            end else begin
              s.left = s.left - 14'd1;
              if (s.left == '0) begin
                s.mode = MODE_OFF;
                s.gap  = 1'b0;
              end else begin
                s.gap     = 1'b1;
                s.elapsed = '0;
              end
            end
          end else if (s.elapsed >= s.len) begin
            s.gap     = 1'b0;
            s.elapsed = '0;
          end
        end
        default: ;
      endcase
    end
    nxt = s;
  end

endmodule

>>> hdl/igpc_core.sv
// ----------------------------------------------------------------------------
// igpc_core
// command decode, watchdog, fault latch, top state and channel state registers
// ----------------------------------------------------------------------------
module igpc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [2:0]          action,
  input  logic [1:0]          channel_number,
  input  logic [15:0]         pulse_duration_ms,
  input  logic [13:0]         pulse_count,
  input  logic                interlock_level,
  input  logic [2:0]          overcurrent_flags,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  output igpc_pkg::result_t   result
);
  import igpc_pkg::*;

  logic [15:0] wdog_timeout_r;
  logic        ilk_pol_r;
  logic        fault_r, fault_nxt;
  logic [15:0] ms_r, ms_nxt;

  chan_t chan_r    [CHANNELS];
  chan_t chan_nxt  [CHANNELS];
  logic  gate_nxt  [CHANNELS];
  chctl_t ctl      [CHANNELS];

  action_t    act;
  logic       ilk_ok;
  logic [2:0] oc;
  logic       is_tick, is_chcmd, ch_ok, dur_ok, cnt_ok, cmd_go;
  rcode_t     code;
  top_t       top;

  assign act     = action_t'(action);
  assign ilk_ok  = ilk_pol_r ? interlock_level : !interlock_level;
  assign oc      = overcurrent_flags & OC_MASK;
  assign is_tick = (act == ACT_TICK);
  assign is_chcmd = (act == ACT_CH_OFF) || (act == ACT_CH_DC) || (act == ACT_CH_PULSE);
  assign ch_ok   = (channel_number != 2'd0) && (int'(channel_number) <= CHANNELS);
  assign dur_ok  = (pulse_duration_ms >= DUR_MIN) && (pulse_duration_ms <= DUR_MAX);
  assign cnt_ok  = (pulse_count >= CNT_MIN) && (pulse_count <= CNT_MAX);
  assign cmd_go  = is_chcmd && (code == RC_OK);

  always_comb begin
    if (!is_tick) begin
      ms_nxt = '0;
    end else if (ms_r != 16'hFFFF) begin
      ms_nxt = ms_r + 16'd1;
    end else begin
      ms_nxt = ms_r;
    end
  end

  always_comb begin
    code = RC_OK;
    case (act)
      ACT_CH_OFF, ACT_CH_DC, ACT_CH_PULSE: begin
        if (!ilk_ok || fault_r) begin
          code = RC_NOT_READY;
        end else if (!ch_ok) begin
          code = RC_BAD_CHAN;
        end else if ((act == ACT_CH_PULSE) && !dur_ok) begin
          code = RC_DUR_RANGE;
        end else if ((act == ACT_CH_PULSE) && !cnt_ok) begin
          code = RC_CNT_RANGE;
        end
      end
      ACT_CLR_FAULT: begin
        if (oc != 3'd0) begin
          code = RC_FAULT_ACTIVE;
        end else if (!ilk_ok) begin
          code = RC_ILK_NOT_READY;
        end
      end
      default: code = RC_OK;
    endcase
  end

  always_comb begin
    fault_nxt = fault_r;
    if ((act == ACT_CLR_FAULT) && (code == RC_OK)) begin
      fault_nxt = 1'b0;
    end
    if (oc != 3'd0) begin
      fault_nxt = 1'b1;
    end
    if (!ilk_ok) begin
      top = TOP_SAFE_ILK;
    end else if (ms_nxt > wdog_timeout_r) begin
      top = TOP_SAFE_WDOG;
    end else if (fault_nxt) begin
      top = TOP_FAULT;
    end else begin
      top = TOP_READY;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    always_comb begin
      ctl[c].tick  = is_tick;
      ctl[c].ready = (top == TOP_READY);
      ctl[c].dur   = pulse_duration_ms;
      ctl[c].cnt   = pulse_count;
      ctl[c].cmd   = CHCMD_NONE;
      if (act == ACT_STOP_ALL) begin
        ctl[c].cmd = CHCMD_OFF;
      end else if (cmd_go && (int'(channel_number) == c + 1)) begin
        unique case (act)
          ACT_CH_OFF:   ctl[c].cmd = CHCMD_OFF;
          ACT_CH_DC:    ctl[c].cmd = CHCMD_DC;
          ACT_CH_PULSE: ctl[c].cmd = CHCMD_PULSE;
          default:      ctl[c].cmd = CHCMD_NONE;
        endcase
      end
    end

    igpc_channel u_chan (
      .cur  (chan_r[c]),
      .ctl  (ctl[c]),
      .nxt  (chan_nxt[c]),
      .gate (gate_nxt[c])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        chan_r[c].mode    <= MODE_OFF;
        chan_r[c].len     <= LEN_RESET;
        chan_r[c].left    <= '0;
        chan_r[c].elapsed <= '0;
        chan_r[c].gap     <= 1'b0;
      end else if (accept) begin
        chan_r[c] <= chan_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= 1'b0;
      ms_r    <= '0;
    end else if (accept) begin
      fault_r <= fault_nxt;
      ms_r    <= ms_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wdog_timeout_r <= WDOG_RESET;
      ilk_pol_r      <= ILK_POL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WDOG_TIMEOUT: wdog_timeout_r <= cfg_wdata;
        CFG_ILK_POL:      ilk_pol_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    result.code  = code;
    result.top   = top;
    result.fault = fault_nxt;
    result.gates = '0;
    result.modes = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      result.gates[c]       = gate_nxt[c];
      result.modes[2*c +: 2] = chan_nxt[c].mode;
    end
  end

endmodule

>>> hdl/igpc_outbuf.sv
// ----------------------------------------------------------------------------
// igpc_outbuf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
module igpc_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  igpc_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output igpc_pkg::result_t out_data
);
  import igpc_pkg::*;

  logic    main_v_r, skid_v_r;
  result_t main_r, skid_r;
  logic    pop;

  assign pop       = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end
      main_v_r <= 1'b1;
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

endmodule

>>> hdl/interlocked_gate_pulse_controller_top.sv
// ----------------------------------------------------------------------------
// interlocked_gate_pulse_controller_top
// three-channel gate controller with interlock, watchdog and overcurrent latch
// ----------------------------------------------------------------------------
// One transaction (tick or command) is accepted per clock cycle. Its result
// is computed in the same cycle from the channel, watchdog and fault state
// registers and goes to the output register, or to the skid register while a
// stalled result holds the output register. A two-entry output buffer lets
// the input keep accepting while a result waits; the input stalls only once
// both entries are held. There is no clearing pass after reset.
module interlocked_gate_pulse_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [1:0]  in_channel_number,
  input  logic [15:0] in_pulse_duration_ms,
  input  logic [13:0] in_pulse_count,
  input  logic        in_interlock_level,
  input  logic [2:0]  in_overcurrent_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_code,
  output logic [1:0]  out_top_state,
  output logic [2:0]  out_gate_levels,
  output logic [5:0]  out_channel_modes,
  output logic        out_fault_flag,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import igpc_pkg::*;

  logic    accept;
  result_t res, res_out;

  assign accept = in_valid && !in_stall;

  igpc_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .action            (in_action),
    .channel_number    (in_channel_number),
    .pulse_duration_ms (in_pulse_duration_ms),
    .pulse_count       (in_pulse_count),
    .interlock_level   (in_interlock_level),
    .overcurrent_flags (in_overcurrent_flags),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .result            (res)
  );

  igpc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_out)
  );

  assign out_result_code   = res_out.code;
  assign out_top_state     = res_out.top;
  assign out_gate_levels   = res_out.gates;
  assign out_channel_modes = res_out.modes;
  assign out_fault_flag    = res_out.fault;

endmodule
